// File: design/npc_pkg.sv
// Package for the nearest palette colour block: sizes, item codes and the
// controller state type. No dependencies.
package npc_pkg;

  // Default palette depth and the reach of the 4-bit entry index
  localparam int PaletteSizeDefault = 16;
  localparam int IndexReach         = 16;

  // Field widths
  localparam int ChanW  = 8;
  localparam int IdxW   = 4;
  localparam int CountW = 5;
  localparam int SqW    = 2 * ChanW;
  localparam int DistW  = 18;
  localparam int WordW  = 4 * ChanW;

  // Largest possible distance: three channels of 255 squared
  localparam logic [DistW-1:0] MaxDist = DistW'(3 * 255 * 255);

  // Request codes on the func field
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Search controller
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN
  } npc_state_e;

endpackage

// File: design/nearest_palette_colour.sv
// A write request gives no result. A lookup over
// n entries (n = palette_count clamped to 1..min(PALETTE_SIZE,16)) reads them
// one at a time through the one read port of the palette RAM; no new request is
// taken until its result is loaded into the output register.
// Reset: controller and palette_count (to 1) clear asynchronously; the palette
// RAM is not cleared and must be written before it is searched.
module nearest_palette_colour #(
  parameter int PALETTE_SIZE = npc_pkg::PaletteSizeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: palette_count
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [npc_pkg::CountW-1:0]    cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [npc_pkg::IdxW-1:0]      entry_index_i,
  input  logic [npc_pkg::ChanW-1:0]     in_red_i,
  input  logic [npc_pkg::ChanW-1:0]     in_green_i,
  input  logic [npc_pkg::ChanW-1:0]     in_blue_i,
  input  logic [npc_pkg::ChanW-1:0]     in_alpha_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [npc_pkg::ChanW-1:0]     out_red_o,
  output logic [npc_pkg::ChanW-1:0]     out_green_o,
  output logic [npc_pkg::ChanW-1:0]     out_blue_o,
  output logic [npc_pkg::ChanW-1:0]     out_alpha_o,
  output logic [npc_pkg::IdxW-1:0]      match_index_o,
  output logic [npc_pkg::DistW-1:0]     match_distance_o
);
  import npc_pkg::*;

  localparam int AddrW     = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int MaxSearch = (PALETTE_SIZE < IndexReach) ? PALETTE_SIZE : IndexReach;

  // ------------------------------------------------------------------
  // Declarations
  // ------------------------------------------------------------------
  npc_state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_clamped;

  logic              in_acc;
  logic              mem_we;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic [WordW-1:0]  palette_mem [PALETTE_SIZE];
  logic [WordW-1:0]  rd_data_q;

  logic              rd_issue;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]   last_q, last_d;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_tag_q;

  logic [ChanW-1:0]  pix_r_q, pix_g_q, pix_b_q;

  logic [ChanW-1:0]  dr, dg, db;
  logic              sq_vld_q;
  logic [IdxW-1:0]   sq_tag_q;
  logic [WordW-1:0]  sq_word_q;
  logic [SqW-1:0]    sq_r_q, sq_g_q, sq_b_q;

  logic [DistW-1:0]  sum_dist;
  logic              take;
  logic [IdxW-1:0]   best_idx_q;
  logic [DistW-1:0]  best_dist_q;
  logic [WordW-1:0]  best_word_q;

  logic              pipe_empty;
  logic              out_load;
  logic              out_valid_q;
  logic [WordW-1:0]  out_word_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [DistW-1:0]  out_dist_q;

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Zero searches one entry; large counts saturate at the reachable depth
  always_comb begin
    if (count_q == '0) begin
      count_clamped = CountW'(1);
    end else if (count_q > CountW'(MaxSearch)) begin
      count_clamped = CountW'(MaxSearch);
    end else begin
      count_clamped = count_q;
    end
  end

  // ------------------------------------------------------------------
  // Controller: next state
  // ------------------------------------------------------------------
  assign in_acc     = in_valid_i && in_ready_o;
  assign pipe_empty = !rd_vld_q && !sq_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && func_i == FUNC_LOOKUP) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rd_idx_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && (!out_valid_q || out_ready_i)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller: outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: rd_issue   = 1'b1;
      ST_DRAIN:  out_load   = pipe_empty && (!out_valid_q || out_ready_i);
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read counter and last entry of this search
  always_comb begin
    rd_idx_d = rd_idx_q;
    last_d   = last_q;
    if (in_acc && func_i == FUNC_LOOKUP) begin
      rd_idx_d = '0;
      last_d   = IdxW'(count_clamped - CountW'(1));
    end else if (rd_issue) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      last_q   <= '0;
      rd_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      last_q   <= last_d;
      rd_vld_q <= rd_issue;
      sq_vld_q <= rd_vld_q;
    end
  end

  // Pixel capture on lookup
  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FUNC_LOOKUP) begin
      pix_r_q <= in_red_i;
      pix_g_q <= in_green_i;
      pix_b_q <= in_blue_i;
    end
  end

  // ------------------------------------------------------------------
  // Palette RAM: writes only in idle, reads issued only while searching, so
  // the two never touch the same entry in flight
  // ------------------------------------------------------------------
  assign mem_we  = in_acc && func_i == FUNC_WRITE &&
                   (32'(entry_index_i) < PALETTE_SIZE);
  assign wr_addr = AddrW'(entry_index_i);
  assign rd_addr = AddrW'(rd_idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[wr_addr] <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    end
    rd_data_q <= palette_mem[rd_addr];
  end

  // ------------------------------------------------------------------
  // Stage 1: absolute differences and squares
  // ------------------------------------------------------------------
  always_comb begin
    dr = (pix_r_q >= rd_data_q[7:0])   ? pix_r_q - rd_data_q[7:0]   : rd_data_q[7:0] - pix_r_q;
    dg = (pix_g_q >= rd_data_q[15:8])  ? pix_g_q - rd_data_q[15:8]  : rd_data_q[15:8] - pix_g_q;
    db = (pix_b_q >= rd_data_q[23:16]) ? pix_b_q - rd_data_q[23:16] : rd_data_q[23:16] - pix_b_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      sq_r_q    <= SqW'(dr) * SqW'(dr);
      sq_g_q    <= SqW'(dg) * SqW'(dg);
      sq_b_q    <= SqW'(db) * SqW'(db);
      sq_tag_q  <= rd_tag_q;
      sq_word_q <= rd_data_q;
    end
    rd_tag_q <= rd_idx_q;
  end

  // ------------------------------------------------------------------
  // Stage 2: sum and keep the strictly smaller distance
  // ------------------------------------------------------------------
  assign sum_dist = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  assign take     = sq_vld_q && ((sq_tag_q == '0) || (sum_dist < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= sq_tag_q;
      best_dist_q <= sum_dist;
      best_word_q <= sq_word_q;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= best_word_q;
      out_idx_q  <= best_idx_q;
      out_dist_q <= best_dist_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_red_o        = out_word_q[7:0];
  assign out_green_o      = out_word_q[15:8];
  assign out_blue_o       = out_word_q[23:16];
  assign out_alpha_o      = out_word_q[31:24];
  assign match_index_o    = out_idx_q;
  assign match_distance_o = out_dist_q;

`ifndef SYNTHESIS
  // read data only follows a read issued while searching
  a_read_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_SEARCH))
    else $error("palette read outside a search");

  // the read counter never passes the last searched entry
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (rd_idx_q <= last_q))
    else $error("read counter past last entry");

  // squared stage carries an entry inside the searched range
  a_tag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_q |-> (sq_tag_q <= last_q))
    else $error("squared stage holds entry beyond search");

  // no request taken while a search is in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || sq_vld_q) |-> !in_ready_o)
    else $error("request accepted during search");

  // reported distance stays within range
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (match_distance_o <= MaxDist))
    else $error("match distance out of range");
`endif

endmodule
